>>> src/hsvc_pkg.sv
// Package for the HSV box color classifier: widths, codes, color tables.
// No dependencies.
package hsvc_pkg;

    localparam int CLASS_COUNT_DEF = 6;
    localparam int NUM_BOXES       = 6;
    localparam int CFG_IDX_W       = 3;
    localparam int BOX_W           = 48;
    localparam logic [2:0] UNDEF_CLASS = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_BOX0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX5    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT = 3'd7;

    localparam logic [1:0] MODE_PASS    = 2'd0;
    localparam logic [1:0] MODE_CURRENT = 2'd1;
    localparam logic [1:0] MODE_SEGMENT = 2'd2;
    localparam logic [1:0] MODE_MASK    = 2'd3;

    typedef struct packed {
        logic [7:0] h;
        logic [7:0] s;
        logic [7:0] v;
    } hsv_t;

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } bgr_t;

    typedef struct packed {
        logic [1:0] view_mode;
        logic [2:0] current_class;
    } view_cfg_t;

    function automatic bgr_t paint_color(input logic [2:0] k);
        bgr_t c;
        unique case (k)
            3'd0:    c = '{8'd0,   8'd127, 8'd255};
            3'd1:    c = '{8'd255, 8'd0,   8'd0};
            3'd2:    c = '{8'd0,   8'd255, 8'd255};
            3'd3:    c = '{8'd0,   8'd255, 8'd0};
            3'd4:    c = '{8'd255, 8'd0,   8'd255};
            3'd5:    c = '{8'd255, 8'd255, 8'd0};
            default: c = '{8'd0,   8'd0,   8'd0};
        endcase
        return c;
    endfunction

    function automatic bgr_t contrast_color(input logic [2:0] k);
        bgr_t c;
        unique case (k)
            3'd0:    c = '{8'd255, 8'd0,   8'd0};
            3'd1:    c = '{8'd0,   8'd127, 8'd255};
            3'd2:    c = '{8'd255, 8'd0,   8'd0};
            3'd3:    c = '{8'd255, 8'd0,   8'd255};
            3'd4:    c = '{8'd0,   8'd255, 8'd0};
            3'd5:    c = '{8'd0,   8'd0,   8'd255};
            default: c = '{8'd0,   8'd0,   8'd0};
        endcase
        return c;
    endfunction

endpackage

>>> src/hsvc_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; used by hsvc_convert.
module hsvc_divider #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 10,
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [NUM_W-1:0] quo,
    output logic [TAG_W-1:0] out_tag
);
    logic             valid_reg [NUM_W+1];
    logic [NUM_W-1:0] rem_reg   [NUM_W+1];
    logic [NUM_W-1:0] q_reg     [NUM_W+1];
    logic [DEN_W-1:0] den_reg   [NUM_W+1];
    logic [TAG_W-1:0] tag_reg   [NUM_W+1];

    always_comb
    begin
        valid_reg[0] = in_valid;
        rem_reg[0]   = num;
        q_reg[0]     = '0;
        den_reg[0]   = den;
        tag_reg[0]   = in_tag;
    end

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        localparam int BIT = NUM_W - 1 - i;
        logic [NUM_W+DEN_W-1:0] shifted;
        logic                   fits;
        always_comb
        begin
            shifted = {{DEN_W{1'b0}}, rem_reg[i]} >> BIT;
            fits    = shifted >= {{NUM_W{1'b0}}, den_reg[i]};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end
        always_ff @(posedge clk)
        begin
            rem_reg[i+1] <= fits ?
                rem_reg[i] - NUM_W'({{NUM_W{1'b0}}, den_reg[i]} << BIT) : rem_reg[i];
            q_reg[i+1]   <= q_reg[i] | (NUM_W'(fits) << BIT);
            den_reg[i+1] <= den_reg[i];
            tag_reg[i+1] <= tag_reg[i];
        end
    end

    assign out_valid = valid_reg[NUM_W];
    assign quo       = q_reg[NUM_W];
    assign out_tag   = tag_reg[NUM_W];
endmodule

>>> src/hsvc_convert.sv
// BGR to HSV conversion pipeline: min/max stage, two dividers, hue fold.
// Depends on hsvc_pkg and hsvc_divider.
module hsvc_convert (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  hsvc_pkg::bgr_t pix,
    output logic          out_valid,
    output hsvc_pkg::bgr_t out_pix,
    output hsvc_pkg::hsv_t hsv
);
    import hsvc_pkg::*;

    localparam int TAG_W = 24 + 8 + 1;

    logic       v1_reg;
    bgr_t       p1_reg;
    logic [7:0] mx1_reg, d1_reg;
    logic [1:0] sext1_reg;
    logic       v1_next;
    logic [7:0] mx, mn;

    always_comb
    begin
        mx = pix.r;
        if (pix.g > mx) mx = pix.g;
        if (pix.b > mx) mx = pix.b;
        mn = pix.r;
        if (pix.g < mn) mn = pix.g;
        if (pix.b < mn) mn = pix.b;
        v1_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg  <= pix;
        mx1_reg <= mx;
        d1_reg  <= mx - mn;
        priority if (mx == pix.r) sext1_reg <= 2'd0;
        else if (mx == pix.g)     sext1_reg <= 2'd1;
        else                      sext1_reg <= 2'd2;
    end

    // numerators: num <= 10*255+255 = 2805; 60*num+d < 2^18
    logic [11:0] hnum;
    logic [17:0] h_n;
    logic [16:0] s_n;
    always_comb
    begin
        unique case (sext1_reg)
            2'd0:    hnum = 12'(p1_reg.g) + 12'(6 * d1_reg) - 12'(p1_reg.b);
            2'd1:    hnum = 12'(p1_reg.b) + 12'(8 * d1_reg) - 12'(p1_reg.r);
            default: hnum = 12'(p1_reg.r) + 12'(10 * d1_reg) - 12'(p1_reg.g);
        endcase
        h_n = 18'(hnum) * 18'd60 + 18'(d1_reg);
        s_n = 17'(d1_reg) * 17'd510 + 17'(mx1_reg);
    end

    logic              sv_o, hv_o;
    logic [16:0]       s_q;
    logic [17:0]       h_q;
    logic [TAG_W-1:0]  s_tag;
    logic              h_tag;

    hsvc_divider #(.NUM_W(17), .DEN_W(9), .TAG_W(TAG_W)) u_sdiv (
        .clk(clk), .rst_n(rst_n), .in_valid(v1_reg), .num(s_n),
        .den({mx1_reg, 1'b0}), .in_tag({p1_reg, mx1_reg, mx1_reg == 8'd0}),
        .out_valid(sv_o), .quo(s_q), .out_tag(s_tag)
    );
    hsvc_divider #(.NUM_W(18), .DEN_W(9), .TAG_W(1)) u_hdiv (
        .clk(clk), .rst_n(rst_n), .in_valid(v1_reg), .num(h_n),
        .den({d1_reg, 1'b0}), .in_tag(d1_reg == 8'd0),
        .out_valid(hv_o), .quo(h_q), .out_tag(h_tag)
    );

    // S divider is one stage shorter: delay it once to align.
    logic             sa_v_reg;
    logic [16:0]      sa_q_reg;
    logic [TAG_W-1:0] sa_tag_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_v_reg <= 1'b0;
        end
        else
        begin
            sa_v_reg <= sv_o;
        end
    end
    always_ff @(posedge clk)
    begin
        sa_q_reg   <= s_q;
        sa_tag_reg <= s_tag;
    end

    // h is 150..330 here; one subtraction folds it into 0..179
    logic [9:0] hf;
    logic [17:0] hx;
    always_comb
    begin
        hx = h_q;
        if (hx >= 18'd180) hx = hx - 18'd180;
        hf = 10'(hx);
    end

    logic v_reg;
    bgr_t p_reg;
    hsv_t hsv_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= hv_o & sa_v_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        p_reg     <= sa_tag_reg[TAG_W-1:9];
        hsv_reg.v <= sa_tag_reg[8:1];
        hsv_reg.s <= sa_tag_reg[0] ? 8'd0 : 8'(sa_q_reg);
        hsv_reg.h <= h_tag ? 8'd0 : 8'(hf);
    end

    assign out_valid = v_reg;
    assign out_pix   = p_reg;
    assign hsv       = hsv_reg;
endmodule

>>> src/hsvc_classify.sv
// Box test, first-match class select and view-mode output mux, two stages.
// Depends on hsvc_pkg.
module hsvc_classify #(
    parameter int CLASS_COUNT = hsvc_pkg::CLASS_COUNT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  hsvc_pkg::bgr_t        pix,
    input  hsvc_pkg::hsv_t        hsv,
    input  logic [hsvc_pkg::BOX_W-1:0] boxes [CLASS_COUNT],
    input  hsvc_pkg::view_cfg_t   vcfg,
    output logic                  out_valid,
    output hsvc_pkg::bgr_t        out_pix,
    output logic [2:0]            class_index,
    output logic                  in_current_box
);
    import hsvc_pkg::*;

    logic [CLASS_COUNT-1:0] hit;
    for (genvar k = 0; k < CLASS_COUNT; k++) begin : g_box
        assign hit[k] = hsv.h >= boxes[k][7:0]   && hsv.h <= boxes[k][31:24] &&
                        hsv.s >= boxes[k][15:8]  && hsv.s <= boxes[k][39:32] &&
                        hsv.v >= boxes[k][23:16] && hsv.v <= boxes[k][47:40];
    end

    logic       v1_reg;
    bgr_t       p1_reg;
    logic [CLASS_COUNT-1:0] hit1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end
    always_ff @(posedge clk)
    begin
        p1_reg   <= pix;
        hit1_reg <= hit;
    end

    logic [2:0] cls;
    logic       cur_ok, flag;
    bgr_t       o;
    always_comb
    begin
        cls = UNDEF_CLASS;
        for (int k = CLASS_COUNT - 1; k >= 0; k--)
            if (hit1_reg[k]) cls = 3'(k);
        cur_ok = 32'(vcfg.current_class) < CLASS_COUNT;
        flag = 1'b0;
        for (int k = 0; k < CLASS_COUNT; k++)
            if (vcfg.current_class == 3'(k)) flag = hit1_reg[k];
        o = p1_reg;
        unique case (vcfg.view_mode)
            MODE_CURRENT:
            begin
                if (!cur_ok) o = '0;
                else if (cls != vcfg.current_class) o = contrast_color(vcfg.current_class);
            end
            MODE_SEGMENT: o = paint_color(cls);
            MODE_PASS, MODE_MASK: o = p1_reg;
            default: o = p1_reg;
        endcase
    end

    logic       v2_reg;
    bgr_t       o_reg;
    logic [2:0] cls_reg;
    logic       flag_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        o_reg    <= o;
        cls_reg  <= cls;
        flag_reg <= flag & cur_ok;
    end

    assign out_valid      = v2_reg;
    assign out_pix        = o_reg;
    assign class_index    = cls_reg;
    assign in_current_box = flag_reg;

    a_flag_cls: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && flag_reg |-> cls_reg != UNDEF_CLASS)
        else $error("flag set on unmatched pixel");
    a_valid_follow: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |=> v2_reg)
        else $error("valid lost in classify");
    a_cls_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (cls_reg < 3'(CLASS_COUNT) || cls_reg == UNDEF_CLASS))
        else $error("class out of range");
endmodule

>>> src/hsv_box_color_classifier_top.sv
// Top level of the HSV box color classifier.
// Depends on hsvc_pkg, hsvc_convert, hsvc_classify.
//
// Usage: raise start with blue/green/red; busy is always low, so one pixel
// is taken every cycle. done goes high for one cycle once the pixel has
// passed, in order, one min/max stage, an 18-stage bit-per-stage hue
// divider, a fold stage, box test and output mux stages. Throughput is one
// pixel per cycle. Configuration uses cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high; write registers only while no pixel is in flight.
// Reset clears the config registers (boxes, mode, current class to zero) and
// drains the pipeline valids. The receiver cannot stall; done is never held.
module hsv_box_color_classifier_top #(
    parameter int CLASS_COUNT = hsvc_pkg::CLASS_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  blue,
    input  logic [7:0]  green,
    input  logic [7:0]  red,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [hsvc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hsvc_pkg::BOX_W-1:0]     cfg_data,
    output logic        done,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_green,
    output logic [7:0]  out_red,
    output logic [2:0]  class_index,
    output logic        in_current_box
);
    import hsvc_pkg::*;

    logic [BOX_W-1:0] box_reg [CLASS_COUNT];
    view_cfg_t        vcfg_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CLASS_COUNT; k++) box_reg[k] <= '0;
            vcfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int k = 0; k < CLASS_COUNT; k++)
                if (cfg_index == CFG_IDX_W'(k) && cfg_index <= REG_BOX5)
                    box_reg[k] <= cfg_data;
            if (cfg_index == REG_VIEW)    vcfg_reg.view_mode     <= cfg_data[1:0];
            if (cfg_index == REG_CURRENT) vcfg_reg.current_class <= cfg_data[2:0];
        end
    end

    logic cv_valid;
    bgr_t in_pix;
    bgr_t cv_pix;
    hsv_t cv_hsv;
    bgr_t res;

    assign in_pix = {blue, green, red};

    hsvc_convert u_convert (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy),
        .pix(in_pix),
        .out_valid(cv_valid), .out_pix(cv_pix), .hsv(cv_hsv)
    );

    hsvc_classify #(.CLASS_COUNT(CLASS_COUNT)) u_classify (
        .clk(clk), .rst_n(rst_n), .in_valid(cv_valid), .pix(cv_pix), .hsv(cv_hsv),
        .boxes(box_reg), .vcfg(vcfg_reg), .out_valid(done), .out_pix(res),
        .class_index(class_index), .in_current_box(in_current_box)
    );

    assign out_blue  = res.b;
    assign out_green = res.g;
    assign out_red   = res.r;
endmodule

>>> tb/sv/hsvc_checker.sv
`timescale 1ns / 100ps
// Checker for the HSV box color classifier: watches config writes, accepted
// pixels and done strobes, predicts each result and compares. Uses hsvc_pkg.
module hsvc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [7:0]  blue,
    input  logic [7:0]  green,
    input  logic [7:0]  red,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [hsvc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hsvc_pkg::BOX_W-1:0]     cfg_data,
    input  logic        done,
    input  logic [7:0]  out_blue,
    input  logic [7:0]  out_green,
    input  logic [7:0]  out_red,
    input  logic [2:0]  class_index,
    input  logic        in_current_box,
    output int          fail_count,
    output int          pending_count,
    output int          pixel_count
);
    import hsvc_pkg::*;

    typedef struct packed {
        bgr_t       pix;
        logic [2:0] cls;
        logic       flag;
    } pixel_result_t;

    logic [BOX_W-1:0] box_bounds [NUM_BOXES];
    logic [1:0]       mode_reg;
    logic [2:0]       cur_class;
    pixel_result_t    result_fifo [$];

    function automatic hsv_t rgb_to_hsv(input logic [7:0] b, g, r);
        int mx, mn, d, num, h;
        hsv_t o;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        o.v = 8'(mx);
        o.s = (mx == 0) ? 8'd0 : 8'((510 * d + mx) / (2 * mx));
        if (d == 0)
        begin
            o.h = 8'd0;
        end
        else
        begin
            if (mx == r) num = g + 6 * d - b;
            else if (mx == g) num = b + 8 * d - r;
            else num = r + 10 * d - g;
            h = (60 * num + d) / (2 * d);
            o.h = 8'(h % 180);
        end
        return o;
    endfunction

    function automatic logic box_hit(input logic [BOX_W-1:0] w, input hsv_t x);
        return x.h >= w[7:0] && x.h <= w[31:24] && x.s >= w[15:8] && x.s <= w[39:32]
            && x.v >= w[23:16] && x.v <= w[47:40];
    endfunction

    function automatic bgr_t paint_of(input logic [2:0] k);
        case (k)
            3'd0: return '{8'd0, 8'd127, 8'd255};
            3'd1: return '{8'd255, 8'd0, 8'd0};
            3'd2: return '{8'd0, 8'd255, 8'd255};
            3'd3: return '{8'd0, 8'd255, 8'd0};
            3'd4: return '{8'd255, 8'd0, 8'd255};
            3'd5: return '{8'd255, 8'd255, 8'd0};
            default: return '{8'd0, 8'd0, 8'd0};
        endcase
    endfunction

    function automatic bgr_t contrast_of(input logic [2:0] k);
        case (k)
            3'd0: return '{8'd255, 8'd0, 8'd0};
            3'd1: return '{8'd0, 8'd127, 8'd255};
            3'd2: return '{8'd255, 8'd0, 8'd0};
            3'd3: return '{8'd255, 8'd0, 8'd255};
            3'd4: return '{8'd0, 8'd255, 8'd0};
            default: return '{8'd0, 8'd0, 8'd255};
        endcase
    endfunction

    function automatic pixel_result_t classify_pixel(input bgr_t p);
        pixel_result_t o;
        hsv_t x;
        logic cur_ok;
        x = rgb_to_hsv(p.b, p.g, p.r);
        o.cls = UNDEF_CLASS;
        for (int k = NUM_BOXES - 1; k >= 0; k--)
            if (box_hit(box_bounds[k], x)) o.cls = 3'(k);
        cur_ok = cur_class < NUM_BOXES;
        o.flag = cur_ok ? box_hit(box_bounds[cur_class], x) : 1'b0;
        o.pix = p;
        if (mode_reg == MODE_CURRENT)
        begin
            if (!cur_ok) o.pix = '0;
            else if (o.cls != cur_class) o.pix = contrast_of(cur_class);
        end
        else if (mode_reg == MODE_SEGMENT)
        begin
            o.pix = paint_of(o.cls);
        end
        return o;
    endfunction

    assign pending_count = result_fifo.size();

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t exp_r;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_BOXES; k++) box_bounds[k] = '0;
            mode_reg = MODE_PASS;
            cur_class = '0;
            fail_count = 0;
            pixel_count = 0;
            result_fifo.delete();
        end
        else
        begin
            if (done)
            begin
                if (result_fifo.size() == 0)
                begin
                    $error("unexpected result");
                    fail_count++;
                end
                else
                begin
                    exp_r = result_fifo.pop_front();
                    if (out_blue !== exp_r.pix.b)
                    begin
                        $error("out_blue exp %0d got %0d", exp_r.pix.b, out_blue);
                        fail_count++;
                    end
                    if (out_green !== exp_r.pix.g)
                    begin
                        $error("out_green exp %0d got %0d", exp_r.pix.g, out_green);
                        fail_count++;
                    end
                    if (out_red !== exp_r.pix.r)
                    begin
                        $error("out_red exp %0d got %0d", exp_r.pix.r, out_red);
                        fail_count++;
                    end
                    if (class_index !== exp_r.cls)
                    begin
                        $error("class_index exp %0d got %0d", exp_r.cls, class_index);
                        fail_count++;
                    end
                    if (in_current_box !== exp_r.flag)
                    begin
                        $error("in_current_box exp %0d got %0d", exp_r.flag,
                               in_current_box);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                result_fifo.push_back(classify_pixel('{blue, green, red}));
                pixel_count++;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_VIEW) mode_reg = cfg_data[1:0];
                else if (cfg_index == REG_CURRENT) cur_class = cfg_data[2:0];
                else box_bounds[cfg_index] = cfg_data;
            end
        end
    end
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench top for hsv_box_color_classifier_top: drives pixels and config
// writes, hsvc_checker predicts and compares. Uses hsvc_pkg.
module tb;
    import hsvc_pkg::*;

    logic clk = 0, rst_n = 0, start = 0, cfg_valid = 0;
    logic [7:0] blue = 0, green = 0, red = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BOX_W-1:0] cfg_data = '0;
    logic busy, cfg_ready, done, in_current_box;
    logic [7:0] out_blue, out_green, out_red;
    logic [2:0] class_index;
    int fail_count, pending_count, pixel_count;
    int idle_pct;

    always #1 clk = ~clk;

    hsv_box_color_classifier_top uut (.*);
    hsvc_checker chk (.*);

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BOX_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic send_pixel(input logic [7:0] b, g, r);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            @(posedge clk);
        end
        start <= 1;
        blue <= b; green <= g; red <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic drain;
        int guard;
        start <= 0;
        guard = 0;
        @(posedge clk);
        while (pending_count != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [BOX_W-1:0] rand_box;
        logic [7:0] lo [3], hi [3];
        for (int c = 0; c < 3; c++)
        begin
            lo[c] = 8'($urandom_range(200));
            hi[c] = 8'(lo[c] + $urandom_range(255 - lo[c]));
            if ($urandom_range(15) == 0) hi[c] = lo[c] - 8'd1;
        end
        if ($urandom_range(7) == 0) return BOX_W'({$urandom, $urandom});
        return {hi[2], hi[1], hi[0], lo[2], lo[1], lo[0]};
    endfunction

    task automatic rand_config(input logic [1:0] mode, input logic [2:0] cur);
        for (int k = 0; k < NUM_BOXES; k++)
            write_reg(REG_BOX0 + CFG_IDX_W'(k), rand_box());
        write_reg(REG_VIEW, BOX_W'(mode));
        write_reg(REG_CURRENT, BOX_W'(cur));
    endtask

    initial
    begin
        #200000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        logic [7:0] dv [8];
        dv = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd254, 8'd127, 8'd85, 8'd170};
        idle_pct = 25;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // all-zero boxes: only black matches
        send_pixel(0, 0, 0);
        send_pixel(255, 255, 255);
        drain();
        write_reg(REG_BOX0, 48'hFF_FF_B3_00_00_00);
        write_reg(REG_BOX5, 48'h00_00_00_FF_FF_FF); // empty
        for (int m = 0; m < 4; m++)
        begin
            write_reg(REG_VIEW, BOX_W'(m));
            write_reg(REG_CURRENT, (m == 1) ? BOX_W'(7) : BOX_W'(0));
            for (int i = 0; i < 5; i++)
                send_pixel(dv[$urandom_range(7)], dv[$urandom_range(7)],
                           dv[$urandom_range(7)]);
            drain();
        end
        for (int ph = 0; ph < 16; ph++)
        begin
            idle_pct = (ph < 6) ? 25 : (ph < 12) ? 68 : 0;
            rand_config(2'(ph % 4),
                        (ph % 5 == 4) ? 3'(6 + ph % 2) : 3'($urandom_range(5)));
            for (int i = 0; i < 100; i++)
            begin
                if ($urandom_range(3) == 0)
                    send_pixel(dv[$urandom_range(7)], dv[$urandom_range(7)],
                               dv[$urandom_range(7)]);
                else
                    send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            end
            drain();
        end
        $display("Covered %0d pixels over all view modes, random and empty boxes,",
                 pixel_count);
        $display("and current class values in and out of range.");
        if (fail_count == 0 && pending_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

>>> files.f
src/hsvc_pkg.sv
src/hsvc_divider.sv
src/hsvc_convert.sv
src/hsvc_classify.sv
src/hsv_box_color_classifier_top.sv
tb/sv/hsvc_checker.sv
tb/sv/tb.sv
